// ----- hdl/shared_time_responsibility_accounting_macros.svh -----
// assertion macros for the shared time accounting block
// expects signals clk and arst_n in the scope where a macro is used
`ifndef SHARED_TIME_RESPONSIBILITY_ACCOUNTING_MACROS_SVH
`define SHARED_TIME_RESPONSIBILITY_ACCOUNTING_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock outside reset
`define STRA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// expression must never be true outside reset
`define STRA_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define STRA_ASSERT(lbl, prop, msg)
`define STRA_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ----- hdl/stra_pkg.sv -----
// shared constants, types and helpers for the shared time accounting block
// used by stra_div, stra_cell and the top level; depends on nothing
package stra_pkg;

	// sizes
	localparam int MAX_ACTIVE = 16;
	localparam int FRAC_BITS  = 16;
	localparam int TIME_W     = 32;
	localparam int ID_W       = 16;
	localparam int SHARE_W    = 48;
	localparam int CNT_W      = $clog2(MAX_ACTIVE + 1);

	// divider geometry, two quotient bits per cycle
	localparam int DIV_W    = TIME_W + FRAC_BITS;
	localparam int DIVP_W   = DIV_W + (DIV_W % 2);
	localparam int DIV_ITER = DIVP_W / 2;
	localparam int ITER_W   = $clog2(DIV_ITER + 1);
	localparam int QX_W     = (DIVP_W > SHARE_W) ? DIVP_W : SHARE_W;

	localparam logic [SHARE_W-1:0] SHARE_MAX = {SHARE_W{1'b1}};

	// input mode code
	localparam logic MODE_STOP = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_UNKNOWN = 2'd1,
		ST_FULL    = 2'd2
	} stra_status_t;

	// control states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_UPDATE,
		S_FINISH
	} stra_state_t;

	// command token that walks the cell chain
	typedef struct packed {
		logic               valid;
		logic               update;  // 0 search pass, 1 update pass
		logic               stop;
		logic [ID_W-1:0]    id;
		logic [SHARE_W-1:0] q;
		logic               found;
		logic               placed;
		logic [SHARE_W-1:0] share;
	} stra_tok_t;

	// saturating share add
	function automatic logic [SHARE_W-1:0] sat_add(input logic [SHARE_W-1:0] a,
	                                                input logic [SHARE_W-1:0] b);
		logic [SHARE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SHARE_W] ? SHARE_MAX : s[SHARE_W-1:0];
	endfunction

endpackage

// ----- hdl/stra_div.sv -----
// iterative restoring divider, two quotient bits per cycle
// depends on stra_pkg
module stra_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [stra_pkg::DIVP_W-1:0] dividend,
	input  logic [stra_pkg::CNT_W-1:0]  divisor,
	output logic                        busy,
	output logic [stra_pkg::DIVP_W-1:0] quotient
);

	logic [stra_pkg::DIVP_W-1:0] work_q;
	logic [stra_pkg::CNT_W-1:0]  rem_q;
	logic [stra_pkg::CNT_W-1:0]  dsr_q;
	logic [stra_pkg::ITER_W-1:0] cnt_q;
	logic [stra_pkg::DIVP_W-1:0] work_d;
	logic [stra_pkg::CNT_W-1:0]  rem_d;

	// two shift-subtract steps
	always_comb begin
		logic [stra_pkg::CNT_W:0] rs;
		work_d = work_q;
		rem_d  = rem_q;
		for (int k = 0; k < 2; k++) begin
			rs     = {rem_d, work_d[stra_pkg::DIVP_W-1]};
			work_d = {work_d[stra_pkg::DIVP_W-2:0], 1'b0};
			if (rs >= {1'b0, dsr_q}) begin
				rs        = rs - {1'b0, dsr_q};
				work_d[0] = 1'b1;
			end
			rem_d = rs[stra_pkg::CNT_W-1:0];
		end
	end

	// iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= stra_pkg::ITER_W'(stra_pkg::DIV_ITER);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
		end else if (cnt_q != '0) begin
			work_q <= work_d;
			rem_q  <= rem_d;
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = work_q;

endmodule

// ----- hdl/stra_cell.sv -----
// one table entry of the cell chain: task id, share and occupancy
// depends on stra_pkg; passes the command token on to its neighbor each cycle
module stra_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  stra_pkg::stra_tok_t tok_in,
	output stra_pkg::stra_tok_t tok_out,
	output logic                occupied
);

	logic                         valid_q;
	logic [stra_pkg::ID_W-1:0]    task_q;
	logic [stra_pkg::SHARE_W-1:0] share_q;
	stra_pkg::stra_tok_t          tok_q;

	logic                         valid_d;
	logic [stra_pkg::ID_W-1:0]    task_d;
	logic [stra_pkg::SHARE_W-1:0] share_d;
	logic [stra_pkg::SHARE_W-1:0] share_sum;
	logic                         match;
	stra_pkg::stra_tok_t          tok_d;

	assign match     = valid_q && (task_q == tok_in.id);
	assign share_sum = stra_pkg::sat_add(share_q, tok_in.q);

	// apply the passing token to this entry
	always_comb begin
		tok_d   = tok_in;
		valid_d = valid_q;
		task_d  = task_q;
		share_d = share_q;
		if (tok_in.valid) begin
			if (!tok_in.update) begin
				if (match) begin
					tok_d.found = 1'b1;
				end
			end else if (valid_q) begin
				share_d = share_sum;
				if (tok_in.stop && match) begin
					tok_d.share = share_sum;
					valid_d     = 1'b0;
				end
			end else if (!tok_in.stop && !tok_in.found && !tok_in.placed) begin
				valid_d      = 1'b1;
				task_d       = tok_in.id;
				share_d      = '0;
				tok_d.placed = 1'b1;
			end
		end
	end

	// occupancy and token stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			valid_q <= valid_d;
			tok_q   <= tok_d;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		task_q  <= task_d;
		share_q <= share_d;
	end

	assign tok_out  = tok_q;
	assign occupied = valid_q;

endmodule

// ----- hdl/shared_time_responsibility_accounting.sv -----
// Shared time accounting: each start/stop item first splits the time since the
// previous item evenly over the active tasks (32.16 fixed point, truncated,
// saturating at 48 bits), then enters, ignores or retires the task. The task
// table is a chain of MAX_ACTIVE cells. An accepted item sends a search token
// down the chain while a radix-4 divider forms the per-task quotient, then an
// update token walks the chain adding the quotient and inserting or removing
// the entry. The update token starts only once the search token has left the
// chain and the divider is done. An item that yields a result then waits for
// the output register to free up. The next item is taken only once the
// previous one is through, also while a result sits unread in the output
// register. A stop yields the task's share, status 0; a stop of an unknown
// task yields status 1 and a start on a full table status 2, both share zero.
// Depends on stra_pkg, stra_div, stra_cell and the macros header.
`include "shared_time_responsibility_accounting_macros.svh"

module shared_time_responsibility_accounting (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] event_time_ms,
	input  logic [15:0] task_id,
	input  logic        mode,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] done_task_id,
	output logic [47:0] share_ms,
	output logic [1:0]  status
);

	stra_pkg::stra_state_t state_q, state_d;

	logic [stra_pkg::TIME_W-1:0]  last_time_q;
	logic [stra_pkg::CNT_W-1:0]   active_cnt_q;
	logic [stra_pkg::ID_W-1:0]    id_q;
	logic                         stop_q;
	logic                         cnt_zero_q;
	logic                         seen_q;
	logic                         found_q;

	logic [stra_pkg::ID_W-1:0]    res_id_q;
	logic [stra_pkg::SHARE_W-1:0] res_share_q;
	stra_pkg::stra_status_t       res_status_q;

	logic                         out_valid_q;
	logic [stra_pkg::ID_W-1:0]    out_id_q;
	logic [stra_pkg::SHARE_W-1:0] out_share_q;
	stra_pkg::stra_status_t       out_status_q;

	logic                         accept;
	logic                         go;
	logic                         srch_phase;
	logic                         load_out;
	logic                         finish_upd;
	logic                         has_res;
	logic                         cnt_inc;
	logic                         cnt_dec;
	stra_pkg::stra_status_t       res_status_d;
	logic [stra_pkg::SHARE_W-1:0] res_share_d;

	logic [stra_pkg::TIME_W-1:0]  elapsed;
	logic [stra_pkg::DIVP_W-1:0]  dividend;
	logic                         div_busy;
	logic [stra_pkg::DIVP_W-1:0]  quot;
	logic [stra_pkg::QX_W-1:0]    quot_x;
	logic [stra_pkg::SHARE_W-1:0] q_use;

	stra_pkg::stra_tok_t          tok_head;
	stra_pkg::stra_tok_t          tok_chain [0:stra_pkg::MAX_ACTIVE];
	stra_pkg::stra_tok_t          tok_exit;
	logic                         tok_srch_out;
	logic                         tok_upd_out;
	logic [stra_pkg::MAX_ACTIVE-1:0] occ;

	logic                         cnt_over;
	logic                         cnt_agree;

	assign in_ready     = (state_q == stra_pkg::S_IDLE);
	assign accept       = in_valid && in_ready;
	assign srch_phase   = (state_q == stra_pkg::S_SEARCH);
	assign tok_exit     = tok_chain[stra_pkg::MAX_ACTIVE];
	assign tok_srch_out = tok_exit.valid && !tok_exit.update;
	assign tok_upd_out  = tok_exit.valid && tok_exit.update;

	// elapsed time, clamped at zero when time runs backwards
	assign elapsed  = (event_time_ms >= last_time_q) ? (event_time_ms - last_time_q) : '0;
	assign dividend = stra_pkg::DIVP_W'(elapsed) << stra_pkg::FRAC_BITS;

	stra_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (dividend),
		.divisor  (active_cnt_q),
		.busy     (div_busy),
		.quotient (quot)
	);

	// saturate the quotient to the share width, zero when no task was active
	assign quot_x = stra_pkg::QX_W'(quot);
	always_comb begin
		if (cnt_zero_q) begin
			q_use = '0;
		end else if (quot_x > stra_pkg::QX_W'(stra_pkg::SHARE_MAX)) begin
			q_use = stra_pkg::SHARE_MAX;
		end else begin
			q_use = stra_pkg::SHARE_W'(quot_x);
		end
	end

	assign go = seen_q && !div_busy;

	// token injection at the head of the chain
	always_comb begin
		tok_head = '0;
		if (accept) begin
			tok_head.valid = 1'b1;
			tok_head.stop  = (mode == stra_pkg::MODE_STOP);
			tok_head.id    = task_id;
		end else if (srch_phase && go) begin
			tok_head.valid  = 1'b1;
			tok_head.update = 1'b1;
			tok_head.stop   = stop_q;
			tok_head.id     = id_q;
			tok_head.q      = q_use;
			tok_head.found  = found_q;
		end
	end

	assign tok_chain[0] = tok_head;

	// chain of table cells
	for (genvar g = 0; g < stra_pkg::MAX_ACTIVE; g++) begin : g_cell
		stra_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_in   (tok_chain[g]),
			.tok_out  (tok_chain[g+1]),
			.occupied (occ[g])
		);
	end

	// result of the update pass
	assign finish_upd = (state_q == stra_pkg::S_UPDATE) && tok_upd_out;
	always_comb begin
		has_res      = 1'b0;
		cnt_inc      = 1'b0;
		cnt_dec      = 1'b0;
		res_status_d = stra_pkg::ST_DONE;
		res_share_d  = '0;
		if (tok_exit.stop) begin
			has_res = 1'b1;
			if (tok_exit.found) begin
				cnt_dec      = 1'b1;
				res_share_d  = tok_exit.share;
			end else begin
				res_status_d = stra_pkg::ST_UNKNOWN;
			end
		end else if (!tok_exit.found) begin
			if (tok_exit.placed) begin
				cnt_inc = 1'b1;
			end else begin
				has_res      = 1'b1;
				res_status_d = stra_pkg::ST_FULL;
			end
		end
	end

	assign load_out = (state_q == stra_pkg::S_FINISH) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stra_pkg::S_IDLE: begin
				if (accept) state_d = stra_pkg::S_SEARCH;
			end
			stra_pkg::S_SEARCH: begin
				if (go) state_d = stra_pkg::S_UPDATE;
			end
			stra_pkg::S_UPDATE: begin
				if (finish_upd) state_d = has_res ? stra_pkg::S_FINISH : stra_pkg::S_IDLE;
			end
			stra_pkg::S_FINISH: begin
				if (load_out) state_d = stra_pkg::S_IDLE;
			end
			default: state_d = stra_pkg::S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= stra_pkg::S_IDLE;
			last_time_q  <= '0;
			active_cnt_q <= '0;
			seen_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_time_q <= event_time_ms;
			end
			if (finish_upd && cnt_inc) begin
				active_cnt_q <= active_cnt_q + 1'b1;
			end else if (finish_upd && cnt_dec) begin
				active_cnt_q <= active_cnt_q - 1'b1;
			end
			if (accept) begin
				seen_q <= 1'b0;
			end else if (tok_srch_out) begin
				seen_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q       <= task_id;
			stop_q     <= (mode == stra_pkg::MODE_STOP);
			cnt_zero_q <= (active_cnt_q == '0);
		end
		if (tok_srch_out) begin
			found_q <= tok_exit.found;
		end
		if (finish_upd) begin
			res_id_q     <= tok_exit.id;
			res_share_q  <= res_share_d;
			res_status_q <= res_status_d;
		end
		if (load_out) begin
			out_id_q     <= res_id_q;
			out_share_q  <= res_share_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign done_task_id = out_id_q;
	assign share_ms     = out_share_q;
	assign status       = out_status_q;

	// checks
	assign cnt_over  = (active_cnt_q > stra_pkg::CNT_W'(stra_pkg::MAX_ACTIVE));
	assign cnt_agree = ($countones(occ) == 32'(active_cnt_q));

	`STRA_ASSERT_NEVER(a_cnt_range, cnt_over, "active count above table size")
	`STRA_ASSERT(a_cnt_matches, in_ready |-> cnt_agree, "active count disagrees with cells")
	`STRA_ASSERT_NEVER(a_upd_exit, tok_upd_out && !finish_upd, "stray update token")
	`STRA_ASSERT_NEVER(a_srch_exit, tok_srch_out && !srch_phase, "stray search token")

endmodule
